// ===== rtl/core/amkd_pkg.sv =====
// Shared types and constants for the desktop-bus mouse and keyboard device.
// Depends on nothing; imported by every module of the block.
package amkd_pkg;

	// Key matrix
	localparam int KEY_COUNT = 128;
	localparam int KEY_W     = $clog2(KEY_COUNT);

	// Reply descriptor queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Reset values of the bus-visible registers
	localparam logic [7:0] MOUSE_ADDR_RST = 8'h63;
	localparam logic [7:0] MOUSE_HID_RST  = 8'h01;
	localparam logic [7:0] KBD_ADDR_RST   = 8'h62;
	localparam logic [7:0] KBD_TYPE_RST   = 8'h05;
	localparam logic [2:0] KBD_LED_RST    = 3'b111;

	// Item kinds
	localparam logic [1:0] KIND_CMD     = 2'd0;
	localparam logic [1:0] KIND_PRESS   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// Bus command fields
	localparam logic [1:0] CMD_LISTEN = 2'd2;
	localparam logic [1:0] CMD_TALK   = 2'd3;
	localparam logic [1:0] REG_1      = 2'd1;
	localparam logic [1:0] REG_2      = 2'd2;
	localparam logic [1:0] REG_3      = 2'd3;

	// Listen register 3 low-byte codes
	localparam logic [7:0] LSN_SET_ADDR = 8'hfe;
	localparam logic [7:0] LSN_SET_BITS = 8'h00;
	localparam logic [7:0] LSN_HID_1    = 8'h01;
	localparam logic [7:0] LSN_HID_2    = 8'h02;
	localparam logic [7:0] LSN_HID_4    = 8'h04;

	// Modifier key codes
	localparam logic [KEY_W-1:0] KEY_DEL    = 7'h6b;
	localparam logic [KEY_W-1:0] KEY_CLEAR  = 7'h47;
	localparam logic [KEY_W-1:0] KEY_CMD    = 7'h37;
	localparam logic [KEY_W-1:0] KEY_OPTION = 7'h3a;
	localparam logic [KEY_W-1:0] KEY_SHIFT  = 7'h38;
	localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h36;
	localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h39;
	localparam logic [KEY_W-1:0] KEY_FDEL   = 7'h75;

	// Reply byte counts
	localparam logic [7:0] PAIR_COUNT = 8'd2;
	localparam int         ID_LEN     = 9;
	localparam int         IDX_W      = $clog2(ID_LEN);

	typedef enum logic [1:0] {
		RPL_ZERO,
		RPL_PAIR,
		RPL_ID
	} reply_kind_t;

	typedef struct packed {
		reply_kind_t kind;
		logic [7:0]  byte_a;
		logic [7:0]  byte_b;
	} reply_desc_t;

	// Mouse register-1 identification reply, count byte first
	function automatic logic [7:0] id_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (idx)
			4'd0: b = 8'd8;
			4'd1: b = 8'h61;
			4'd2: b = 8'h70;
			4'd3: b = 8'h70;
			4'd4: b = 8'h6c;
			4'd5: b = 8'h01;
			4'd6: b = 8'h2c;
			4'd7: b = 8'h01;
			4'd8: b = 8'h03;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/amkd_item_if.sv =====
// Input channel: bus commands and key events with valid/ready handshake.
// Depends on nothing.
interface amkd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] command_byte;
	logic [7:0] listen_hi;
	logic [7:0] listen_lo;
	logic [6:0] key_code;
	logic [3:0] random_nibble;

	modport source (output valid, kind, command_byte, listen_hi, listen_lo, key_code,
		random_nibble, input ready);
	modport sink (input valid, kind, command_byte, listen_hi, listen_lo, key_code,
		random_nibble, output ready);
endinterface

// ===== rtl/core/amkd_reply_if.sv =====
// Output channel: talk reply bytes with last flag, valid/ready handshake.
// Depends on nothing.
interface amkd_reply_if;
	logic       valid;
	logic       ready;
	logic [7:0] reply_byte;
	logic       last_byte;

	modport source (output valid, reply_byte, last_byte, input ready);
	modport sink (input valid, reply_byte, last_byte, output ready);
endinterface

// ===== rtl/core/adb_mouse_keyboard_device.sv =====
// Desktop-bus mouse and keyboard pair, top level.
// Throughput: one item accepted per cycle while the 4-entry reply queue has room;
// replies leave at one byte per cycle while reply.ready holds, set by the byte sequencer.
// A talk's first reply byte passes through a queue entry and then the output register;
// key events, listens and bus resets act at the accepting edge.
// Reset: arst_n clears the key matrix, queue and output and restores all registers.
module adb_mouse_keyboard_device
	import amkd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	amkd_item_if.sink    cmd,
	amkd_reply_if.source reply,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);

	logic        push_valid;
	logic        push_ready;
	reply_desc_t push_desc;
	logic        q_valid;
	reply_desc_t q_desc;
	logic        q_pop;

	amkd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_desc  (push_desc)
	);

	amkd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_desc   (q_desc),
		.pop        (q_pop)
	);

	amkd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_valid),
		.desc       (q_desc),
		.desc_pop   (q_pop),
		.reply      (reply)
	);

endmodule

// ===== rtl/core/amkd_front.sv =====
// Front end: accepts items, holds device registers and key matrix, and
// classifies talks into reply descriptors. Depends on amkd_pkg, amkd_item_if.
module amkd_front
	import amkd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	amkd_item_if.sink        cmd,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             push_ready,
	output logic             push_valid,
	output reply_desc_t      push_desc
);

	logic [7:0]          kbd_type_q;
	logic [7:0]          mouse_addr_q;
	logic [7:0]          mouse_hid_q;
	logic [7:0]          kbd_addr_q;
	logic [7:0]          kbd_hid_q;
	logic [2:0]          kbd_led_q;
	logic [KEY_COUNT-1:0] key_map_q;

	logic [7:0] mouse_addr_d;
	logic [7:0] mouse_hid_d;
	logic [7:0] kbd_addr_d;
	logic [2:0] kbd_led_d;
	logic       accept;
	logic       is_cmd;
	logic       bus_rst;
	logic [3:0] adr;
	logic [1:0] cmd_f;
	logic [1:0] reg_f;
	logic       mouse_hit;
	logic       kbd_hit;
	logic [7:0] mod_hi;
	logic [7:0] mod_lo;

	assign cmd.ready = push_ready;
	assign accept    = cmd.valid && cmd.ready;
	assign is_cmd    = (cmd.kind == KIND_CMD);
	assign bus_rst   = is_cmd && (cmd.command_byte[3:0] == 4'h0);
	assign adr       = cmd.command_byte[7:4];
	assign cmd_f     = cmd.command_byte[3:2];
	assign reg_f     = cmd.command_byte[1:0];
	assign mouse_hit = (adr == mouse_addr_q[3:0]);
	assign kbd_hit   = !mouse_hit && (adr == kbd_addr_q[3:0]);

	// Keyboard register 2 bytes folded from the key matrix and LED state
	assign mod_hi = {1'b1, ~key_map_q[KEY_FDEL], ~key_map_q[KEY_CAPS], 1'b1,
		~key_map_q[KEY_CTRL], ~key_map_q[KEY_SHIFT], ~key_map_q[KEY_OPTION],
		~key_map_q[KEY_CMD]};
	assign mod_lo = {~key_map_q[KEY_CLEAR], ~key_map_q[KEY_DEL], 3'b111, kbd_led_q};

	// Command decode: register updates and reply classification
	always_comb begin
		mouse_addr_d = mouse_addr_q;
		mouse_hid_d  = mouse_hid_q;
		kbd_addr_d   = kbd_addr_q;
		kbd_led_d    = kbd_led_q;
		push_valid   = 1'b0;
		push_desc    = '{kind: RPL_ZERO, byte_a: 8'h00, byte_b: 8'h00};
		if (is_cmd && !bus_rst) begin
			if (mouse_hit) begin
				if (cmd_f == CMD_LISTEN && reg_f == REG_3) begin
					if (cmd.listen_lo == LSN_SET_ADDR)
						mouse_addr_d = {mouse_addr_q[7:4], cmd.listen_hi[3:0]};
					else if (cmd.listen_lo == LSN_HID_1 || cmd.listen_lo == LSN_HID_2
						|| cmd.listen_lo == LSN_HID_4)
						mouse_hid_d = cmd.listen_lo;
					else if (cmd.listen_lo == LSN_SET_BITS)
						mouse_addr_d = (mouse_addr_q & 8'hd0) | (cmd.listen_hi & 8'h2f);
				end else if (cmd_f == CMD_TALK) begin
					push_valid = 1'b1;
					if (reg_f == REG_1) begin
						push_desc.kind = RPL_ID;
					end else if (reg_f == REG_3) begin
						push_desc.kind   = RPL_PAIR;
						push_desc.byte_a = {mouse_addr_q[7:4], cmd.random_nibble};
						push_desc.byte_b = mouse_hid_q;
					end
				end
			end else if (kbd_hit) begin
				if (cmd_f == CMD_LISTEN) begin
					if (reg_f == REG_2) begin
						kbd_led_d = cmd.listen_lo[2:0];
					end else if (reg_f == REG_3) begin
						if (cmd.listen_lo == LSN_SET_ADDR)
							kbd_addr_d = {kbd_addr_q[7:4], cmd.listen_hi[3:0]};
						else if (cmd.listen_lo == LSN_SET_BITS)
							kbd_addr_d = (kbd_addr_q & 8'hd0) | (cmd.listen_hi & 8'h2f);
					end
				end else if (cmd_f == CMD_TALK) begin
					push_valid = 1'b1;
					if (reg_f == REG_2) begin
						push_desc.kind   = RPL_PAIR;
						push_desc.byte_a = mod_hi;
						push_desc.byte_b = mod_lo;
					end else if (reg_f == REG_3) begin
						push_desc.kind   = RPL_PAIR;
						push_desc.byte_a = {kbd_addr_q[7:4], cmd.random_nibble};
						push_desc.byte_b = kbd_hid_q;
					end
				end
			end else if (cmd_f == CMD_TALK) begin
				push_valid = 1'b1;
			end
		end
		push_valid = push_valid && accept;
	end

	// Device registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbd_type_q   <= KBD_TYPE_RST;
			mouse_addr_q <= MOUSE_ADDR_RST;
			mouse_hid_q  <= MOUSE_HID_RST;
			kbd_addr_q   <= KBD_ADDR_RST;
			kbd_hid_q    <= KBD_TYPE_RST;
			kbd_led_q    <= KBD_LED_RST;
		end else if (cfg_we) begin
			kbd_type_q <= cfg_wdata;
			kbd_hid_q  <= cfg_wdata;
		end else if (accept && bus_rst) begin
			mouse_addr_q <= MOUSE_ADDR_RST;
			mouse_hid_q  <= MOUSE_HID_RST;
			kbd_addr_q   <= KBD_ADDR_RST;
			kbd_hid_q    <= kbd_type_q;
			kbd_led_q    <= KBD_LED_RST;
		end else if (accept) begin
			mouse_addr_q <= mouse_addr_d;
			mouse_hid_q  <= mouse_hid_d;
			kbd_addr_q   <= kbd_addr_d;
			kbd_led_q    <= kbd_led_d;
		end
	end

	// Key matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_q <= '0;
		end else if (accept && cmd.kind == KIND_PRESS) begin
			key_map_q[cmd.key_code] <= 1'b1;
		end else if (accept && cmd.kind == KIND_RELEASE) begin
			key_map_q[cmd.key_code] <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/amkd_queue.sv =====
// Short queue of reply descriptors between front and back.
// Depends on amkd_pkg.
module amkd_queue
	import amkd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	input  reply_desc_t push_desc,
	output logic        push_ready,
	output logic        pop_valid,
	output reply_desc_t pop_desc,
	input  logic        pop
);

	reply_desc_t       entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QUEUE_DEPTH[QPTR_W:0]);
	assign pop_valid  = (count_q != '0);
	assign pop_desc   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_desc;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/amkd_back.sv =====
// Back end: expands descriptors into count and data bytes, popping each with
// its last byte, via an output register. Depends on amkd_pkg, amkd_reply_if.
module amkd_back
	import amkd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        desc_valid,
	input  reply_desc_t desc,
	output logic        desc_pop,
	amkd_reply_if.source reply
);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             load;
	logic [7:0]       sel_byte;
	logic             sel_last;

	assign load     = desc_valid && (!out_valid_q || reply.ready);
	assign desc_pop = load && sel_last;

	// Byte selection for the current position in the reply
	always_comb begin
		sel_byte = 8'h00;
		sel_last = 1'b1;
		unique case (desc.kind)
			RPL_PAIR: begin
				sel_last = (idx_q == IDX_W'(2));
				if (idx_q == '0)
					sel_byte = PAIR_COUNT;
				else if (idx_q == IDX_W'(1))
					sel_byte = desc.byte_a;
				else
					sel_byte = desc.byte_b;
			end
			RPL_ID: begin
				sel_last = (idx_q == IDX_W'(ID_LEN - 1));
				sel_byte = id_byte(idx_q);
			end
			default: begin
				sel_byte = 8'h00;
				sel_last = 1'b1;
			end
		endcase
	end

	// Byte position and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= sel_last ? '0 : idx_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (reply.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= sel_byte;
			out_last_q <= sel_last;
		end
	end

	assign reply.valid      = out_valid_q;
	assign reply.reply_byte = out_byte_q;
	assign reply.last_byte  = out_last_q;

endmodule
